FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define FRCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication from one cycle to the next.
`define FRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> cons) else $error(msg);

`endif

FILE: rtl/core/frcs_pkg.sv
// Package of the frame repeat cadence scheduler: constants, slot entry type, sequencer states.
package frcs_pkg;

  localparam int unsigned WINDOW_DEPTH = 8;
  localparam int unsigned SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);
  localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [2:0] REG_STRICT_THR  = 3'd0;
  localparam logic [2:0] REG_RELAXED_THR = 3'd1;
  localparam logic [2:0] REG_REPEAT_TGT  = 3'd2;
  localparam logic [2:0] REG_DRIFT_BOUND = 3'd3;
  localparam logic [2:0] REG_WINDOW      = 3'd4;

  typedef struct packed {
    logic [15:0] rep;
    logic [15:0] prio;
    logic [31:0] idx;
  } entry_t;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_DECIDE = 12'b0000_0000_0010,
    S_A0     = 12'b0000_0000_0100,
    S_A1     = 12'b0000_0000_1000,
    S_M0     = 12'b0000_0001_0000,
    S_MRD    = 12'b0000_0010_0000,
    S_MCHK   = 12'b0000_0100_0000,
    S_MWB    = 12'b0000_1000_0000,
    S_TRD    = 12'b0001_0000_0000,
    S_TCHK   = 12'b0010_0000_0000,
    S_ERD    = 12'b0100_0000_0000,
    S_EMIT   = 12'b1000_0000_0000
  } state_e;

endpackage

FILE: rtl/core/frame_repeat_cadence_scheduler_unit.sv
// Frame repeat cadence scheduler: window of distinct frames in a slot memory, walked by a sequencer.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i, in_stall_o, diff_metric_i,            | into block
//          | end_of_stream_i                                  |
//  out     | out_valid_o, out_stall_i, result_kind_o,          | out of block
//          | new_distinct_o, frame_index_o, repeat_count_o,   |
//          | last_o                                           |
//  cfg     | cfg_we_i, cfg_addr_i, cfg_wdata_i                 | into block
//
// One item is worked on at a time; every slot read goes through the single read port
// of the slot memory, which takes one read and one write a cycle. An emitting item first
// reads the front and middle frames, then trims or pads window entries, or else scans
// the window to move copies to the middle frame when it lacks them, and finally emits
// the front entry, or on a flush every entry of the window.
// Reset clears all control state at once; there is no clearing pass over the memory.
// A stall on the output holds the sequencer at the next word it has to deliver.
module frame_repeat_cadence_scheduler_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] diff_metric_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic        new_distinct_o,
  output logic [31:0] frame_index_o,
  output logic [15:0] repeat_count_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i
);
  import frcs_pkg::*;

  `include "assert_macros.svh"

  state_e state_q, state_d;

  logic [15:0] strict_q, relaxed_thr_q, bound_q;
  logic [7:0]  target_q;
  logic [3:0]  wframes_q;

  logic [SLOT_W-1:0] head_q, head_d, fx_slot_q, fx_slot_d;
  logic [FILL_W-1:0] fill_q, fill_d, k_q, k_d;
  logic              relaxed_q, relaxed_d, seen_q, seen_d;
  logic              flush_q, flush_d, pass2_q, pass2_d, pad_q, pad_d;
  logic [31:0]       fr_q, fr_d, fw_q, fw_d, drift_q, drift_d, idx_q, idx_d;
  logic [3:0]        recheck_q, recheck_d;
  logic [15:0]       metric_q, metric_d;
  entry_t            fx_q, fx_d;

  // Slot memory
  entry_t            mem_q [WINDOW_DEPTH];
  entry_t            rd_q, wd;
  logic              we;
  logic [SLOT_W-1:0] wa, ra;

  // Output register
  logic        ov_q, ov_d, okind_q, okind_d, ond_q, ond_d, olast_q, olast_d;
  logic [31:0] oidx_q, oidx_d;
  logic [15:0] ocnt_q, ocnt_d;

  logic              can_put, accept;
  logic [FILL_W-1:0] win, half, mid_k, fill_m1, k_m1;
  logic [15:0]       thr, t16, rep_inc;
  logic [31:0]       bound32, dnew, dabs, avail, need, n, dmod, dmod_abs;
  logic              cont;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q      <= 16'd128;
      relaxed_thr_q <= 16'd64;
      target_q      <= 8'd2;
      bound_q       <= 16'd5;
      wframes_q     <= 4'd7;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_STRICT_THR:  strict_q      <= cfg_wdata_i;
        REG_RELAXED_THR: relaxed_thr_q <= cfg_wdata_i;
        REG_REPEAT_TGT:  target_q      <= cfg_wdata_i[7:0];
        REG_DRIFT_BOUND: bound_q       <= cfg_wdata_i;
        REG_WINDOW:      wframes_q     <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign accept         = in_valid_i && !in_stall_o;
  assign can_put        = !ov_q || !out_stall_i;
  assign out_valid_o    = ov_q;
  assign result_kind_o  = okind_q;
  assign new_distinct_o = ond_q;
  assign frame_index_o  = oidx_q;
  assign repeat_count_o = ocnt_q;
  assign last_o         = olast_q;

  assign win     = (wframes_q == 4'd0) ? FILL_W'(1) :
                   ((FILL_W'(wframes_q) > FILL_W'(WINDOW_DEPTH)) ? FILL_W'(WINDOW_DEPTH)
                                                                 : FILL_W'(wframes_q));
  assign half    = win >> 1;
  assign fill_m1 = fill_q - FILL_W'(1);
  assign k_m1    = k_q - FILL_W'(1);
  assign mid_k   = (half > fill_m1) ? fill_m1 : half;
  assign thr     = relaxed_q ? relaxed_thr_q : strict_q;
  assign t16     = {8'd0, target_q};
  assign bound32 = {16'd0, bound_q};
  assign rep_inc = (rd_q.rep < COUNT_MAX) ? rd_q.rep + 16'd1 : rd_q.rep;

  // Drift for the adjustment, refreshed from the front frame every window-size passes.
  assign dnew = (recheck_q <= 4'd1) ? fw_q - rd_q.idx : drift_q;
  assign dabs = dnew[31] ? ~dnew + 32'd1 : dnew;

  // Trim or pad a whole entry in one step: move as many copies as the drift still needs.
  // With a zero bound padding never stops early, so each entry is filled up to target.
  always_comb begin
    if (pad_q) begin
      avail = (rd_q.rep < t16) ? {16'd0, t16 - rd_q.rep} : 32'd0;
      need  = (bound_q == 16'd0) ? 32'hFFFF_FFFF : (~drift_q + 32'd1) - bound32 + 32'd1;
    end else begin
      avail = (rd_q.rep > t16) ? {16'd0, rd_q.rep - t16} : 32'd0;
      need  = drift_q - bound32 + 32'd1;
    end
    n        = (avail < need) ? avail : need;
    dmod     = pad_q ? drift_q + n : drift_q - n;
    dmod_abs = dmod[31] ? ~dmod + 32'd1 : dmod;
    cont     = pad_q ? (dmod_abs >= bound32) : ($signed(dmod) >= $signed(bound32));
  end

  always_comb begin
    case (state_q)
      S_A0, S_ERD, S_EMIT: ra = head_q;
      S_A1:                ra = head_q + mid_k[SLOT_W-1:0];
      S_M0, S_MRD, S_MCHK: ra = head_q + k_m1[SLOT_W-1:0];
      S_TRD, S_TCHK:       ra = head_q + k_q[SLOT_W-1:0];
      default:             ra = head_q + fill_m1[SLOT_W-1:0];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    fill_d    = fill_q;
    relaxed_d = relaxed_q;
    seen_d    = seen_q;
    flush_d   = flush_q;
    pass2_d   = pass2_q;
    pad_d     = pad_q;
    fr_d      = fr_q;
    fw_d      = fw_q;
    drift_d   = drift_q;
    recheck_d = recheck_q;
    idx_d     = idx_q;
    metric_d  = metric_q;
    k_d       = k_q;
    fx_d      = fx_q;
    fx_slot_d = fx_slot_q;
    we        = 1'b0;
    wa        = head_q;
    wd        = rd_q;
    ov_d      = ov_q && out_stall_i;
    okind_d   = okind_q;
    ond_d     = ond_q;
    oidx_d    = oidx_q;
    ocnt_d    = ocnt_q;
    olast_d   = olast_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          metric_d = diff_metric_i;
          flush_d  = end_of_stream_i;
          idx_d    = fr_q;
          if (!end_of_stream_i) begin
            fr_d = fr_q + 32'd1;
          end
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (flush_q) begin
          if (fill_q == '0) begin
            head_d = '0; fill_d = '0; relaxed_d = 1'b0; seen_d = 1'b0;
            fr_d = '0; fw_d = '0; drift_d = '0; recheck_d = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_A0;
          end
        end else if (can_put) begin
          ov_d    = 1'b1;
          okind_d = 1'b0;
          ond_d   = 1'b1;
          oidx_d  = idx_q;
          ocnt_d  = 16'd1;
          olast_d = 1'b1;
          if (!seen_q || fill_q == '0) begin
            seen_d  = 1'b1;
            we      = 1'b1;
            wa      = head_q + fill_q[SLOT_W-1:0];
            wd      = '{rep: 16'd1, prio: 16'd0, idx: idx_q};
            fill_d  = fill_q + FILL_W'(1);
            state_d = S_IDLE;
          end else if (metric_q < thr) begin
            we      = 1'b1;
            wa      = ra;
            wd.rep  = rep_inc;
            if (rep_inc == t16) begin
              relaxed_d = 1'b1;
            end
            ond_d   = 1'b0;
            oidx_d  = rd_q.idx;
            ocnt_d  = rep_inc;
            state_d = S_IDLE;
          end else begin
            relaxed_d = 1'b0;
            if (fill_q < win) begin
              we      = 1'b1;
              wa      = head_q + fill_q[SLOT_W-1:0];
              wd      = '{rep: 16'd1, prio: metric_q, idx: idx_q};
              fill_d  = fill_q + FILL_W'(1);
              state_d = S_IDLE;
            end else begin
              olast_d = 1'b0;
              state_d = S_A0;
            end
          end
        end
      end

      S_A0: state_d = S_A1;

      S_A1: begin
        drift_d   = dnew;
        recheck_d = (recheck_q <= 4'd1) ? win : recheck_q - 4'd1;
        k_d       = '0;
        if (dabs < bound32) begin
          fx_slot_d = ra;
          state_d   = S_M0;
        end else begin
          pad_d   = !($signed(dnew) >= $signed(bound32));
          state_d = S_TRD;
        end
      end

      // The middle frame is cached here and written back once its copies are settled.
      S_M0: begin
        fx_d = rd_q;
        if (rd_q.rep < t16) begin
          k_d     = fill_q;
          pass2_d = 1'b0;
          state_d = S_MRD;
        end else begin
          state_d = S_ERD;
        end
      end

      S_MRD: state_d = S_MCHK;

      S_MCHK: begin
        if (pass2_q ? (rd_q.prio < fx_q.prio && rd_q.rep > 16'd1) : (rd_q.rep > t16)) begin
          we       = 1'b1;
          wa       = ra;
          wd.rep   = rd_q.rep - 16'd1;
          fx_d.rep = fx_q.rep + 16'd1;
          k_d      = fill_q;
          pass2_d  = 1'b0;
          state_d  = ((fx_q.rep + 16'd1) < t16) ? S_MRD : S_MWB;
        end else if (k_q > FILL_W'(1)) begin
          k_d     = k_m1;
          state_d = S_MRD;
        end else if (!pass2_q) begin
          pass2_d = 1'b1;
          k_d     = fill_q;
          state_d = S_MRD;
        end else begin
          state_d = S_MWB;
        end
      end

      S_MWB: begin
        we      = 1'b1;
        wa      = fx_slot_q;
        wd      = fx_q;
        state_d = S_ERD;
      end

      S_TRD: state_d = S_TCHK;

      S_TCHK: begin
        we      = 1'b1;
        wa      = ra;
        wd.rep  = pad_q ? rd_q.rep + n[15:0] : rd_q.rep - n[15:0];
        drift_d = dmod;
        k_d     = k_q + FILL_W'(1);
        state_d = (cont && (k_q + FILL_W'(1)) < fill_q) ? S_TRD : S_ERD;
      end

      S_ERD: state_d = S_EMIT;

      S_EMIT: begin
        if (can_put) begin
          ov_d    = 1'b1;
          okind_d = 1'b1;
          ond_d   = 1'b0;
          oidx_d  = rd_q.idx;
          ocnt_d  = rd_q.rep;
          olast_d = flush_q ? (fill_q == FILL_W'(1)) : 1'b1;
          fw_d    = fw_q + {16'd0, rd_q.rep};
          head_d  = head_q + SLOT_W'(1);
          if (flush_q) begin
            fill_d = fill_m1;
            if (fill_q == FILL_W'(1)) begin
              head_d = '0; fill_d = '0; relaxed_d = 1'b0; seen_d = 1'b0;
              fr_d = '0; fw_d = '0; drift_d = '0; recheck_d = '0;
              state_d = S_IDLE;
            end else begin
              state_d = S_ERD;
            end
          end else begin
            // The new distinct frame takes the place behind the window.
            we      = 1'b1;
            wa      = head_q + fill_q[SLOT_W-1:0];
            wd      = '{rep: 16'd1, prio: metric_q, idx: idx_q};
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      head_q    <= '0;
      fill_q    <= '0;
      relaxed_q <= 1'b0;
      seen_q    <= 1'b0;
      flush_q   <= 1'b0;
      pass2_q   <= 1'b0;
      pad_q     <= 1'b0;
      fr_q      <= '0;
      fw_q      <= '0;
      drift_q   <= '0;
      recheck_q <= '0;
      k_q       <= '0;
      fx_slot_q <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      fill_q    <= fill_d;
      relaxed_q <= relaxed_d;
      seen_q    <= seen_d;
      flush_q   <= flush_d;
      pass2_q   <= pass2_d;
      pad_q     <= pad_d;
      fr_q      <= fr_d;
      fw_q      <= fw_d;
      drift_q   <= drift_d;
      recheck_q <= recheck_d;
      k_q       <= k_d;
      fx_slot_q <= fx_slot_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    metric_q <= metric_d;
    idx_q    <= idx_d;
    fx_q     <= fx_d;
    okind_q  <= okind_d;
    ond_q    <= ond_d;
    oidx_q   <= oidx_d;
    ocnt_q   <= ocnt_d;
    olast_q  <= olast_d;
  end

  `FRCS_ASSERT(a_fill_bound, fill_q <= FILL_W'(WINDOW_DEPTH), "window fill beyond depth")
  `FRCS_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "accepted word not taken up")
  `FRCS_ASSERT(a_emit_nonempty, state_q != S_EMIT || fill_q != '0, "emit from an empty window")

endmodule
